// ----- hdl/hdc_pkg.sv -----
// Shared types, sizes and result codes for the instruction hazard detector.
`timescale 1ns / 1ps
`default_nettype none

package hdc_pkg;

   // Window size and derived widths
   localparam int WINDOW_DEPTH = 16;
   localparam int REG_COUNT    = 32;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

   // Fixed field widths of the request and response
   localparam int REG_W  = 5;
   localparam int KIND_W = 3;
   localparam int OIDX_W = 4;

   // Dependency kinds
   localparam logic [KIND_W-1:0] KIND_RAW  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WAR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WAW  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NONE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FULL = 3'd4;

   // Bit positions inside a cell's hit flags
   localparam int HIT_RAW = 0;
   localparam int HIT_WAR = 1;
   localparam int HIT_WAW = 2;

   // One decoded instruction as stored in the window
   typedef struct packed {
      logic [REG_W-1:0] dst;
      logic             dst_ok;
      logic [REG_W-1:0] sa;
      logic             sa_ok;
      logic [REG_W-1:0] sb;
      logic             sb_ok;
   } entry_type;

   // Scan data handed from cell to cell toward the head
   typedef struct packed {
      logic [2:0]       hits;
      logic [REG_W-1:0] dst;
   } scan_type;

   // Window position reduced to the 4-bit index field
   function automatic logic [OIDX_W-1:0] to_oidx(input logic [IDX_W-1:0] v);
      logic [IDX_W+OIDX_W-1:0] w;
      w = {{OIDX_W{1'b0}}, v};
      return w[OIDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hdc_cell.sv -----
// One window cell: holds an earlier instruction and its hit flags for the scan.
`timescale 1ns / 1ps
`default_nettype none

module hdc_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire hdc_pkg::entry_type cur,
   input  wire logic               live,
   input  wire logic               load,
   input  wire logic               shift,
   input  wire logic [2:0]         clr_mask,
   input  wire hdc_pkg::scan_type  chain_in,
   output hdc_pkg::scan_type       scan_out,
   output logic [2:0]              hit
);
   import hdc_pkg::*;

   entry_type entry_ff;
   scan_type  scan_ff;
   scan_type  scan_in;

   // Compare the stored instruction against the arriving one
   always_comb begin
      hit[HIT_RAW] = entry_ff.dst_ok &&
                     ((cur.sa_ok && entry_ff.dst == cur.sa) ||
                      (cur.sb_ok && entry_ff.dst == cur.sb));
      hit[HIT_WAR] = cur.dst_ok &&
                     ((entry_ff.sa_ok && entry_ff.sa == cur.dst) ||
                      (entry_ff.sb_ok && entry_ff.sb == cur.dst));
      hit[HIT_WAW] = entry_ff.dst_ok && cur.dst_ok && entry_ff.dst == cur.dst;
      if (!live) begin
         hit = 3'b000;
      end
   end

   // Capture flags, advance toward the head, or drop reported flags
   always_comb begin
      scan_in = scan_ff;
      if (load) begin
         scan_in.hits = hit;
         scan_in.dst  = entry_ff.dst;
      end else if (shift) begin
         scan_in = chain_in;
      end else begin
         scan_in.hits = scan_ff.hits & ~clr_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.hits <= 3'b000;
      end else begin
         scan_ff.hits <= scan_in.hits;
      end
      scan_ff.dst <= scan_in.dst;
   end

   // Store the instruction when this cell is the next free position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= cur;
      end
   end

   assign scan_out = scan_ff;

endmodule

`default_nettype wire

// ----- hdl/instruction_hazard_detector_top.sv -----
// Top level of the instruction hazard detector: cell row, scan sequencer, response register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | start_program, dest/src_a/src_b reg + present
//   rsp     | out       | rsp_valid/rsp_stall | dep_kind, earlier/later index, shared_reg, last
//
// A request whose window is full, or that hits nothing, gives its single response in the
// cycle after acceptance. Otherwise the cell row shifts its hit flags toward the head cell,
// at most one response per cycle unless stalled, up to 3*(WINDOW_DEPTH-1) = 45 responses.
// A new request is taken once the last response is registered and the output is free.
// Reset empties the window; stored entries are not cleared. A stalled response holds the
// scan while the head cell holds hits.
`timescale 1ns / 1ps
`default_nettype none

module instruction_hazard_detector_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_start_program,
   input  wire logic [hdc_pkg::REG_W-1:0]  req_dest_reg,
   input  wire logic                       req_dest_present,
   input  wire logic [hdc_pkg::REG_W-1:0]  req_src_a_reg,
   input  wire logic                       req_src_a_present,
   input  wire logic [hdc_pkg::REG_W-1:0]  req_src_b_reg,
   input  wire logic                       req_src_b_present,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [hdc_pkg::KIND_W-1:0]      rsp_dep_kind,
   output logic [hdc_pkg::OIDX_W-1:0]      rsp_earlier_index,
   output logic [hdc_pkg::OIDX_W-1:0]      rsp_later_index,
   output logic [hdc_pkg::REG_W-1:0]       rsp_shared_reg,
   output logic                            rsp_last_result
);
   import hdc_pkg::*;

   entry_type          cur;
   scan_type           scan [WINDOW_DEPTH];
   logic [2:0]         hits [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] hit_any;
   logic [WINDOW_DEPTH-1:0] pend_vec;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               scan_active_ff, scan_active_in;
   logic [IDX_W-1:0]   head_idx_ff, head_idx_in;
   logic [IDX_W-1:0]   later_ff, later_in;
   logic [REG_W-1:0]   cur_dst_ff, cur_dst_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [OIDX_W-1:0]  early_ff, early_in;
   logic [OIDX_W-1:0]  late_ff, late_in;
   logic [REG_W-1:0]   shreg_ff, shreg_in;
   logic               last_ff, last_in;

   logic               accept, out_free, full, any_hit, rest_any;
   logic [COUNT_W-1:0] eff_count;
   logic [IDX_W-1:0]   pos;
   logic               head_empty, emit, shift, load;
   logic [2:0]         pick, remain;

   // Arriving instruction
   assign cur.dst    = req_dest_reg;
   assign cur.dst_ok = req_dest_present;
   assign cur.sa     = req_src_a_reg;
   assign cur.sa_ok  = req_src_a_present;
   assign cur.sb     = req_src_b_reg;
   assign cur.sb_ok  = req_src_b_present;

   // Handshake and window position
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = scan_active_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign eff_count = req_start_program ? '0 : count_ff;
   assign full      = eff_count == COUNT_W'(WINDOW_DEPTH);
   assign pos       = eff_count[IDX_W-1:0];
   assign load      = accept && !full;

   // Row of window cells
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      scan_type chain_in;
      if (i == WINDOW_DEPTH - 1) begin : g_tail
         assign chain_in = '0;
      end else begin : g_link
         assign chain_in = scan[i+1];
      end

      hdc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (load && pos == IDX_W'(i)),
         .cur      (cur),
         .live     (COUNT_W'(i) < eff_count),
         .load     (load),
         .shift    (shift),
         .clr_mask ((i == 0 && emit) ? pick : 3'b000),
         .chain_in (chain_in),
         .scan_out (scan[i]),
         .hit      (hits[i])
      );

      assign hit_any[i]  = |hits[i];
      assign pend_vec[i] = |scan[i].hits;
   end

   assign any_hit  = |hit_any;
   assign rest_any = |pend_vec[WINDOW_DEPTH-1:1];

   // Pick the next kind at the head cell: RAW, then WAR, then WAW
   always_comb begin
      pick = 3'b000;
      if (scan[0].hits[HIT_RAW]) begin
         pick[HIT_RAW] = 1'b1;
      end else if (scan[0].hits[HIT_WAR]) begin
         pick[HIT_WAR] = 1'b1;
      end else if (scan[0].hits[HIT_WAW]) begin
         pick[HIT_WAW] = 1'b1;
      end
   end

   assign remain     = scan[0].hits & ~pick;
   assign head_empty = !pend_vec[0];
   assign emit       = scan_active_ff && !head_empty && out_free;
   assign shift      = scan_active_ff && (head_empty || (emit && remain == 3'b000));

   // Sequencer and response register next state
   always_comb begin
      count_in       = count_ff;
      scan_active_in = scan_active_ff;
      head_idx_in    = head_idx_ff;
      later_in       = later_ff;
      cur_dst_in     = cur_dst_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      kind_in        = kind_ff;
      early_in       = early_ff;
      late_in        = late_ff;
      shreg_in       = shreg_ff;
      last_in        = last_ff;

      if (accept) begin
         rsp_valid_in = 1'b0;
         if (full) begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_FULL;
            early_in     = '0;
            late_in      = '0;
            shreg_in     = '0;
            last_in      = 1'b1;
            count_in     = eff_count;
         end else begin
            count_in = eff_count + COUNT_W'(1);
            if (any_hit) begin
               scan_active_in = 1'b1;
               head_idx_in    = '0;
               later_in       = pos;
               cur_dst_in     = req_dest_reg;
            end else begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_NONE;
               early_in     = '0;
               late_in      = to_oidx(pos);
               shreg_in     = '0;
               last_in      = 1'b1;
            end
         end
      end

      // Emit one dependency of the head cell
      if (emit) begin
         rsp_valid_in = 1'b1;
         early_in     = to_oidx(head_idx_ff);
         late_in      = to_oidx(later_ff);
         last_in      = remain == 3'b000 && !rest_any;
         if (pick[HIT_RAW]) begin
            kind_in  = KIND_RAW;
            shreg_in = scan[0].dst;
         end else if (pick[HIT_WAR]) begin
            kind_in  = KIND_WAR;
            shreg_in = cur_dst_ff;
         end else begin
            kind_in  = KIND_WAW;
            shreg_in = cur_dst_ff;
         end
         if (remain == 3'b000 && !rest_any) begin
            scan_active_in = 1'b0;
         end
      end

      // Advance the head index with the row
      if (shift) begin
         head_idx_in = head_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         scan_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         scan_active_ff <= scan_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      head_idx_ff <= head_idx_in;
      later_ff    <= later_in;
      cur_dst_ff  <= cur_dst_in;
      kind_ff     <= kind_in;
      early_ff    <= early_in;
      late_ff     <= late_in;
      shreg_ff    <= shreg_in;
      last_ff     <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dep_kind      = kind_ff;
   assign rsp_earlier_index = early_ff;
   assign rsp_later_index   = late_ff;
   assign rsp_shared_reg    = shreg_ff;
   assign rsp_last_result   = last_ff;

endmodule

`default_nettype wire

// ----- hdl/hdc_checker.sv -----
// Port-level assertions for the instruction hazard detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hdc_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [hdc_pkg::KIND_W-1:0] rsp_dep_kind,
   input wire logic [hdc_pkg::OIDX_W-1:0] rsp_earlier_index,
   input wire logic [hdc_pkg::OIDX_W-1:0] rsp_later_index,
   input wire logic                      rsp_last_result
);
   import hdc_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dep_kind))
      else $error("stalled response dropped or changed");

   // Full and none are always the single, final response of a request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dep_kind == KIND_FULL || rsp_dep_kind == KIND_NONE)
      |-> rsp_last_result)
      else $error("full or none response not marked last");

   // A dependency always points to an older window position
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dep_kind == KIND_RAW || rsp_dep_kind == KIND_WAR ||
                    rsp_dep_kind == KIND_WAW)
      |-> rsp_earlier_index < rsp_later_index)
      else $error("earlier index not below later index");

   // Kind codes stay within the defined set
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dep_kind <= KIND_FULL)
      else $error("undefined dependency kind");

endmodule

bind instruction_hazard_detector_top hdc_checker u_hdc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_dep_kind      (rsp_dep_kind),
   .rsp_earlier_index (rsp_earlier_index),
   .rsp_later_index   (rsp_later_index),
   .rsp_last_result   (rsp_last_result)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the instruction hazard detector with a dependency tracker.
`timescale 1ns / 1ps

module testbench;
   import hdc_pkg::*;

   // One request as driven on the req channel
   typedef struct packed {
      logic      start;
      entry_type insn;
   } request_type;

   // One response as seen on the rsp channel
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OIDX_W-1:0] earlier;
      logic [OIDX_W-1:0] later;
      logic [REG_W-1:0]  shared;
      logic              is_last;
   } response_type;

   // Tracks the instruction window and the hazards each request should report
   class hazard_tracker;
      entry_type    window [WINDOW_DEPTH];
      int           fill_count;
      response_type pending_hazards [$];
      int           mismatches;

      function new();
         fill_count = 0;
         mismatches = 0;
      endfunction

      function void add_result(logic [KIND_W-1:0] kind, int earlier, int later,
                               logic [REG_W-1:0] shared);
         response_type r;
         r.kind    = kind;
         r.earlier = OIDX_W'(earlier);
         r.later   = OIDX_W'(later);
         r.shared  = shared;
         r.is_last = 1'b0;
         pending_hazards.push_back(r);
      endfunction

      // Predict the hazards of an accepted request and store it in the window
      function void note_request(request_type rq);
         entry_type cur;
         entry_type e;
         int        pos;
         int        first;
         cur   = rq.insn;
         first = pending_hazards.size();
         if (rq.start)
            fill_count = 0;
         if (fill_count >= WINDOW_DEPTH) begin
            add_result(KIND_FULL, 0, 0, '0);
         end else begin
            pos = fill_count;
            for (int i = 0; i < pos; i++) begin
               e = window[i];
               // read after write: earlier destination feeds a current source
               if (e.dst_ok && ((cur.sa_ok && cur.sa == e.dst) ||
                                (cur.sb_ok && cur.sb == e.dst)))
                  add_result(KIND_RAW, i, pos, e.dst);
               // write after read: current destination overwrites an earlier source
               if (cur.dst_ok && ((e.sa_ok && e.sa == cur.dst) ||
                                  (e.sb_ok && e.sb == cur.dst)))
                  add_result(KIND_WAR, i, pos, cur.dst);
               // write after write: same destination
               if (cur.dst_ok && e.dst_ok && e.dst == cur.dst)
                  add_result(KIND_WAW, i, pos, cur.dst);
            end
            if (pending_hazards.size() == first)
               add_result(KIND_NONE, 0, pos, '0);
            window[pos] = cur;
            fill_count  = pos + 1;
         end
         pending_hazards[pending_hazards.size() - 1].is_last = 1'b1;
      endfunction

      // Compare a response with the oldest predicted hazard
      function void check_response(response_type got);
         response_type exp;
         if (pending_hazards.size() == 0) begin
            $error("unexpected response: dep_kind %0d earlier %0d later %0d shared %0d",
                   got.kind, got.earlier, got.later, got.shared);
            mismatches++;
            return;
         end
         exp = pending_hazards.pop_front();
         if (got.kind !== exp.kind) begin
            $error("dep_kind: expected %0d, got %0d", exp.kind, got.kind);
            mismatches++;
         end
         if (got.earlier !== exp.earlier) begin
            $error("earlier_index: expected %0d, got %0d", exp.earlier, got.earlier);
            mismatches++;
         end
         if (got.later !== exp.later) begin
            $error("later_index: expected %0d, got %0d", exp.later, got.later);
            mismatches++;
         end
         if (got.shared !== exp.shared) begin
            $error("shared_reg: expected %0d, got %0d", exp.shared, got.shared);
            mismatches++;
         end
         if (got.is_last !== exp.is_last) begin
            $error("last_result: expected %0d, got %0d", exp.is_last, got.is_last);
            mismatches++;
         end
      endfunction

      // Flag hazards that never showed up
      function void flag_leftovers();
         response_type exp;
         while (pending_hazards.size() > 0) begin
            exp = pending_hazards.pop_front();
            $error("missing response: dep_kind %0d earlier %0d later %0d shared %0d",
                   exp.kind, exp.earlier, exp.later, exp.shared);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_start_program;
   logic [REG_W-1:0]    req_dest_reg;
   logic                req_dest_present;
   logic [REG_W-1:0]    req_src_a_reg;
   logic                req_src_a_present;
   logic [REG_W-1:0]    req_src_b_reg;
   logic                req_src_b_present;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [KIND_W-1:0]   rsp_dep_kind;
   logic [OIDX_W-1:0]   rsp_earlier_index;
   logic [OIDX_W-1:0]   rsp_later_index;
   logic [REG_W-1:0]    rsp_shared_reg;
   logic                rsp_last_result;

   hazard_tracker tracker;
   bit            no_idle;

   instruction_hazard_detector_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_program (req_start_program),
      .req_dest_reg      (req_dest_reg),
      .req_dest_present  (req_dest_present),
      .req_src_a_reg     (req_src_a_reg),
      .req_src_a_present (req_src_a_present),
      .req_src_b_reg     (req_src_b_reg),
      .req_src_b_present (req_src_b_present),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dep_kind      (rsp_dep_kind),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_later_index   (rsp_later_index),
      .rsp_shared_reg    (rsp_shared_reg),
      .rsp_last_result   (rsp_last_result)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic request_type make_request(logic start, int d, logic dp, int a,
                                                logic ap, int b, logic bp);
      request_type rq;
      rq.start       = start;
      rq.insn.dst    = REG_W'(d);
      rq.insn.dst_ok = dp;
      rq.insn.sa     = REG_W'(a);
      rq.insn.sa_ok  = ap;
      rq.insn.sb     = REG_W'(b);
      rq.insn.sb_ok  = bp;
      return rq;
   endfunction

   // Favor a few registers so hazards are common, with the full range now and then
   function automatic logic [REG_W-1:0] pick_reg();
      if ($urandom_range(0, 3) == 0)
         return REG_W'($urandom_range(0, 31));
      return REG_W'($urandom_range(0, 3));
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq.start       = ($urandom_range(0, 19) == 0);
      rq.insn.dst    = pick_reg();
      rq.insn.dst_ok = ($urandom_range(0, 4) != 0);
      rq.insn.sa     = pick_reg();
      rq.insn.sa_ok  = ($urandom_range(0, 4) != 0);
      rq.insn.sb     = pick_reg();
      rq.insn.sb_ok  = ($urandom_range(0, 4) != 0);
      return rq;
   endfunction

   // Drive one request after a random gap and hold it until accepted
   task automatic send_request(request_type rq);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_program <= rq.start;
      req_dest_reg      <= rq.insn.dst;
      req_dest_present  <= rq.insn.dst_ok;
      req_src_a_reg     <= rq.insn.sa;
      req_src_a_present <= rq.insn.sa_ok;
      req_src_b_reg     <= rq.insn.sb;
      req_src_b_present <= rq.insn.sb_ok;
      do @(posedge clock); while (req_stall);
      tracker.note_request(rq);
   endtask

   // Request side: reset, directed cases, random traffic, drain and verdict
   initial begin
      tracker            = new();
      no_idle            = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_start_program <= 1'b0;
      req_dest_reg      <= '0;
      req_dest_present  <= 1'b0;
      req_src_a_reg     <= '0;
      req_src_a_present <= 1'b0;
      req_src_b_reg     <= '0;
      req_src_b_present <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Clear the window, then walk the extremes and absent operands
      send_request(make_request(1, 0, 1, 31, 0, 31, 0));
      send_request(make_request(0, 31, 1, 0, 1, 31, 0));
      send_request(make_request(0, 0, 1, 31, 1, 0, 1));
      send_request(make_request(0, 0, 0, 31, 0, 0, 0));
      send_request(make_request(0, 5, 1, 5, 1, 5, 1));
      send_request(make_request(0, 5, 1, 5, 1, 5, 1));
      // Fill the window to its last slot
      for (int k = 0; k < 10; k++)
         send_request(make_request(0, k + 6, 1, k + 5, 1, k, 1'(k % 2)));
      // Window full: refuse, even with no hazards
      send_request(make_request(0, 31, 1, 31, 1, 31, 1));
      send_request(make_request(0, 30, 0, 30, 0, 30, 0));
      // Start on a full window restarts at slot zero
      send_request(make_request(1, 31, 1, 31, 1, 31, 1));
      send_request(make_request(0, 31, 1, 31, 1, 31, 1));

      // Random program streams, with idle-free stretches now and then
      for (int n = 0; n < 450; n++) begin
         if (n % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         send_request(random_request());
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray response
      while (tracker.pending_hazards.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      tracker.flag_leftovers();
      if (tracker.mismatches == 0)
         $display("instruction_hazard_detector_top regression: pass");
      else
         $display("instruction_hazard_detector_top regression: fail");
      $finish;
   end

   // Response side: stall at random, check every accepted response
   initial begin
      response_type got;
      int           hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.kind    = rsp_dep_kind;
         got.earlier = rsp_earlier_index;
         got.later   = rsp_later_index;
         got.shared  = rsp_shared_reg;
         got.is_last = rsp_last_result;
         tracker.check_response(got);
      end
   end

   // Watchdog: stop a hung run
   initial begin
      #3000000;
      $display("instruction_hazard_detector_top regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/hdc_pkg.sv
hdl/hdc_cell.sv
hdl/instruction_hazard_detector_top.sv
hdl/hdc_checker.sv
dv/testbench.sv
